// File: hw/rtl/rtre_pkg.sv
// rtre_pkg: shared types and constants of the retry-aware rtt/rto estimator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rtre_pkg;
	localparam logic [1:0] ST_MEASURED = 2'd0;
	localparam logic [1:0] ST_IGNORED  = 2'd1;
	localparam logic [1:0] ST_CLEARED  = 2'd2;

	localparam logic [1:0] REG_FLOOR = 2'd0;
	localparam logic [1:0] REG_CEIL  = 2'd1;
	localparam logic [1:0] REG_INIT  = 2'd2;
	localparam logic [1:0] REG_MULT  = 2'd3;

	// one elapsed port per transmission on the top level
	localparam int MAX_SENDS = 4;

	localparam logic [16:0] W_MEAN_OLD = 17'd19661;
	localparam logic [16:0] W_MEAN_NEW = 17'd45875;
	localparam logic [16:0] W_VAR_OLD  = 17'd8192;
	localparam logic [16:0] W_VAR_NEW  = 17'd57344;
	localparam logic [19:0] RTO_MIN = 20'd5;
	localparam logic [19:0] RTO_MAX = 20'hFFFFF;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture item, choose and clamp rtt, push to window
		logic clr;     // clear estimator state
		logic skip;    // item without transmissions, state kept
		logic init;    // start recompute with the oldest sample
		logic step;    // one ewma step over the next sample
		logic fin;     // store mean/var
		logic emit;    // register result fields
	} rtre_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;    // no more window samples to fold in
	} rtre_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/rtre_ctrl.sv
// rtre_ctrl: sequencer of the estimator
// depends on rtre_pkg
`timescale 1ns / 1ps
`default_nettype none
module rtre_ctrl import rtre_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        in_opcode,
	input  wire  [2:0] in_sent,
	output logic       out_valid,
	input  wire        out_stall,
	output rtre_cmd_t  cmd,
	input  rtre_sts_t  sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INIT = 3'd1;
	localparam logic [2:0] S_STEP = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic       take;

	// result register frees at transfer, so a new item can come in meanwhile
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign take = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.load = take && !in_opcode && (in_sent != 3'd0);
		cmd.clr  = take && in_opcode;
		cmd.skip = take && !in_opcode && (in_sent == 3'd0);
		cmd.emit = (take && (in_opcode || in_sent == 3'd0)) || (state_q == S_EMIT);
		cmd.init = (state_q == S_INIT);
		cmd.step = (state_q == S_STEP) && !sts.last;
		cmd.fin  = (state_q == S_STEP) && sts.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_INIT;
				S_INIT: state_q <= S_STEP;
				S_STEP: if (sts.last) state_q <= S_EMIT;
				S_FIN:  state_q <= S_EMIT;
				S_EMIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/rtre_dp.sv
// rtre_dp: datapath with window, min tracking, shared ewma multipliers and rto
// depends on rtre_pkg
`timescale 1ns / 1ps
`default_nettype none
module rtre_dp import rtre_pkg::*; #(
	parameter int WINDOW_DEPTH = 6
) (
	input  wire         clk,
	input  wire         arst_n,
	input  rtre_cmd_t   cmd,
	output rtre_sts_t   sts,
	input  wire  [2:0]  sent_count,
	input  wire  [MAX_SENDS*16-1:0] elapsed,
	input  wire  [15:0] rtt_floor,
	input  wire  [15:0] rtt_ceiling,
	input  wire  [15:0] initial_rtt,
	input  wire  [3:0]  rto_multiplier,
	output logic [1:0]  status,
	output logic [15:0] raw_rtt,
	output logic [19:0] rto_ms,
	output logic [23:0] mean_rtt,
	output logic [23:0] var_rtt
);
	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int NW = $clog2(MAX_SENDS + 1);

	logic [15:0]   win_q [WINDOW_DEPTH];
	logic [CW-1:0] cnt_q;
	logic          min_known_q, mean_known_q;
	logic [15:0]   min_q, raw_q;
	logic [23:0]   mean_reg_q, var_reg_q, mean_q, var_q;
	logic [CW-1:0] idx_q;

	// transmission choice: newest reaching the minimum, else the oldest
	logic [NW-1:0] n;
	logic [15:0]   pick, rtt_c, e;
	always_comb begin
		if (sent_count > 3'(MAX_SENDS)) n = NW'(MAX_SENDS);
		else n = NW'(sent_count);
		pick = elapsed[15:0];
		for (int i = 0; i < MAX_SENDS; i++) begin
			e = elapsed[i*16 +: 16];
			if (i < int'(n) && min_known_q && e >= min_q) pick = e;
		end
		if (n == NW'(1)) pick = elapsed[15:0];
		rtt_c = pick;
		if (n == NW'(1) && (!min_known_q || pick < min_q)) begin
			// minimum updated to this rtt, so no raise
			rtt_c = pick;
		end else if (!min_known_q && pick < rtt_floor) rtt_c = rtt_floor;
		else if (min_known_q && pick < min_q) rtt_c = min_q;
		if (rtt_c > rtt_ceiling) rtt_c = rtt_ceiling;
	end

	// ewma step over window entry idx_q
	logic [15:0] s;
	logic [23:0] sq, d;
	logic [39:0] vn, mn;
	assign s  = win_q[idx_q[IW-1:0]];
	assign sq = {s, 8'd0};
	assign d  = (sq >= mean_q) ? sq - mean_q : mean_q - sq;
	assign vn = 40'(W_VAR_OLD) * 40'(var_q) + 40'(W_VAR_NEW) * 40'(d) + 40'd32768;
	assign mn = 40'(W_MEAN_OLD) * 40'(mean_q) + 40'(W_MEAN_NEW) * 40'(sq) + 40'd32768;
	assign sts.last = (idx_q >= cnt_q);

	// rto from current estimate; a clear reports the initial mean
	logic [23:0] m_e, v_e;
	logic [26:0] sum;
	logic [30:0] x;
	logic [22:0] r;
	assign m_e = (mean_known_q && !cmd.clr) ? mean_reg_q : {initial_rtt, 8'd0};
	assign v_e = (mean_known_q && !cmd.clr) ? var_reg_q : 24'd0;
	assign sum = 27'(m_e) + {1'b0, v_e, 2'b00};
	assign x   = 31'(rto_multiplier) * 31'(sum);
	assign r   = 23'((32'(x) + 32'd255) >> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			min_known_q <= 1'b0;
			mean_known_q <= 1'b0;
			min_q <= '0;
			mean_reg_q <= '0;
			var_reg_q <= '0;
		end else begin
			if (cmd.clr) begin
				cnt_q <= '0;
				min_known_q <= 1'b0;
				mean_known_q <= 1'b0;
				min_q <= '0;
				mean_reg_q <= '0;
				var_reg_q <= '0;
			end
			if (cmd.load) begin
				if (n == NW'(1) && (!min_known_q || pick < min_q)) begin
					min_q <= pick;
					min_known_q <= 1'b1;
				end
				if (cnt_q >= CW'(WINDOW_DEPTH)) cnt_q <= CW'(WINDOW_DEPTH);
				else cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.fin) begin
				mean_reg_q <= mean_q;
				var_reg_q <= var_q;
				mean_known_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q <= pick;
			if (cnt_q >= CW'(WINDOW_DEPTH)) begin
				for (int i = 0; i < WINDOW_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
				win_q[WINDOW_DEPTH-1] <= rtt_c;
			end else win_q[cnt_q[IW-1:0]] <= rtt_c;
		end
		if (cmd.init) begin
			mean_q <= {win_q[0], 8'd0};
			var_q  <= {1'b0, win_q[0], 7'd0};
			idx_q  <= CW'(1);
		end
		if (cmd.step) begin
			var_q  <= vn[39:16];
			mean_q <= mn[39:16];
			idx_q  <= idx_q + CW'(1);
		end
		if (cmd.emit) begin
			status <= cmd.clr ? ST_CLEARED : (cmd.skip ? ST_IGNORED : ST_MEASURED);
			raw_rtt <= (cmd.clr || cmd.skip) ? 16'd0 : raw_q;
			mean_rtt <= m_e;
			var_rtt <= v_e;
			rto_ms <= (r > 23'(RTO_MAX)) ? RTO_MAX : ((20'(r) < RTO_MIN) ? RTO_MIN : 20'(r));
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/retry_aware_rtt_rto_estimator.sv
// retry_aware_rtt_rto_estimator: top level, config registers, ctrl and datapath
// depends on rtre_pkg, rtre_ctrl, rtre_dp
//
// channel  direction  handshake          payload
// in       input      in_valid/in_stall   opcode, sent_count, elapsed_0..3
// out      output     out_valid/out_stall status, raw_rtt, rto_ms, mean_rtt, var_rtt
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a measure recomputes the estimate over the window samples: one ewma
// step a cycle over the filled window; clear and ignored items are emitted without a recompute
// reset is asynchronous, active low; config and state registers return to their reset values
// a waiting result stalls input only while out_stall holds it
`timescale 1ns / 1ps
`default_nettype none
module retry_aware_rtt_rto_estimator import rtre_pkg::*; #(
	parameter int WINDOW_DEPTH = 6
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         opcode,
	input  wire  [2:0]  sent_count,
	input  wire  [15:0] elapsed_0,
	input  wire  [15:0] elapsed_1,
	input  wire  [15:0] elapsed_2,
	input  wire  [15:0] elapsed_3,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [15:0] raw_rtt,
	output logic [19:0] rto_ms,
	output logic [23:0] mean_rtt,
	output logic [23:0] var_rtt,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	logic [15:0] floor_q, ceil_q, init_q;
	logic [3:0]  mult_q;
	rtre_cmd_t   cmd;
	rtre_sts_t   sts;
	logic [MAX_SENDS*16-1:0] el4;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 16'd10;
			ceil_q <= 16'd1000;
			init_q <= 16'd250;
			mult_q <= 4'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FLOOR: floor_q <= cfg_data;
				REG_CEIL:  ceil_q <= cfg_data;
				REG_INIT:  init_q <= cfg_data;
				REG_MULT:  mult_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign el4 = {elapsed_3, elapsed_2, elapsed_1, elapsed_0};

	rtre_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_opcode(opcode), .in_sent(sent_count),
		.out_valid, .out_stall, .cmd, .sts
	);

	rtre_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .sent_count, .elapsed(el4),
		.rtt_floor(floor_q), .rtt_ceiling(ceil_q), .initial_rtt(init_q),
		.rto_multiplier(mult_q), .status, .raw_rtt, .rto_ms, .mean_rtt, .var_rtt
	);

`ifndef ASSERT_OFF
	a_rto_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rto_ms >= RTO_MIN) else $error("rto below minimum");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.clr)) else $error("load and clear together");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> in_stall) else $error("input taken mid recompute");
`endif
endmodule
`default_nettype wire

// File: tb/sv/retry_aware_rtt_rto_estimator_test.sv
// retry_aware_rtt_rto_estimator_test: self-checking bench for the rtt/rto estimator
// depends on rtre_pkg and retry_aware_rtt_rto_estimator; predicts every result in-bench
`timescale 1ns / 1ps
module retry_aware_rtt_rto_estimator_test;
	import rtre_pkg::*;

	localparam int DEPTH = 6;
	localparam int SENDS = 4;
	localparam int CYCLE_LIMIT = 900000;

	typedef struct packed {
		logic        op;
		logic [2:0]  cnt;
		logic [15:0] e0, e1, e2, e3;
	} meas_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] raw;
		logic [19:0] rto;
		logic [23:0] mean;
		logic [23:0] var_q;
	} est_t;

	typedef struct {
		meas_t m;
		bit    known;   // expected result typed in
		est_t  r;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_valid = 0;
	logic opcode = 0;
	logic [2:0] sent_count = 0;
	logic [15:0] elapsed_0 = 0, elapsed_1 = 0, elapsed_2 = 0, elapsed_3 = 0;
	logic [1:0] cfg_index = REG_FLOOR;
	logic [15:0] cfg_data = 0;
	wire in_stall, out_valid, cfg_ready;
	wire [1:0] status;
	wire [15:0] raw_rtt;
	wire [19:0] rto_ms;
	wire [23:0] mean_rtt, var_rtt;

	retry_aware_rtt_rto_estimator uut (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [15:0] p_floor, p_ceil, p_init;
	logic [3:0]  p_mult;
	bit          p_min_known, p_mean_known;
	logic [15:0] p_min;
	logic [15:0] p_win[DEPTH];
	int          p_cnt;
	logic [23:0] p_mean, p_var;

	est_t expected_q[$];
	row_t rows[$];
	int errors = 0, n_checked = 0, n_items = 0, cycles = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_off = 0;

	function automatic void clear_estimate();
		p_min_known = 0; p_min = 0; p_cnt = 0;
		p_mean = 0; p_var = 0; p_mean_known = 0;
		foreach (p_win[i]) p_win[i] = 0;
	endfunction

	function automatic est_t estimate_out(logic [1:0] st, logic [15:0] raw);
		est_t r;
		logic [63:0] m, v, x, t;
		m = p_mean_known ? 64'(p_mean) : 64'(p_init) << 8;
		v = p_mean_known ? 64'(p_var) : 64'd0;
		x = 64'(p_mult) * (m + 4 * v);
		t = (x + 255) >> 8;
		if (t > 64'(RTO_MAX)) t = 64'(RTO_MAX);
		if (t < 64'(RTO_MIN)) t = 64'(RTO_MIN);
		r.st = st; r.raw = raw; r.rto = t[19:0];
		r.mean = m[23:0]; r.var_q = v[23:0];
		return r;
	endfunction

	function automatic est_t estimate_step(meas_t m);
		logic [15:0] e[4];
		logic [15:0] rtt, raw;
		logic [63:0] mn, vr, s, d;
		int n;
		e = '{m.e0, m.e1, m.e2, m.e3};
		if (m.op) begin
			clear_estimate();
			return estimate_out(ST_CLEARED, 0);
		end
		n = m.cnt;
		if (n == 0) return estimate_out(ST_IGNORED, 0);
		if (n > SENDS) n = SENDS;
		if (n == 1) begin
			rtt = e[0];
			if (!p_min_known || rtt < p_min) begin
				p_min = rtt; p_min_known = 1;
			end
		end else begin
			rtt = 0;
			for (int i = n; i > 0; i--) begin
				rtt = e[i-1];
				if (p_min_known && rtt >= p_min) break;
			end
		end
		raw = rtt;
		if (!p_min_known && rtt < p_floor) rtt = p_floor;
		else if (p_min_known && rtt < p_min) rtt = p_min;
		if (rtt > p_ceil) rtt = p_ceil;
		if (p_cnt >= DEPTH) begin
			for (int i = 0; i < DEPTH - 1; i++) p_win[i] = p_win[i+1];
			p_cnt = DEPTH - 1;
		end
		p_win[p_cnt] = rtt;
		p_cnt++;
		mn = 64'(p_win[0]) << 8;
		vr = 64'(p_win[0]) << 7;
		for (int i = 1; i < p_cnt; i++) begin
			s = 64'(p_win[i]) << 8;
			d = s >= mn ? s - mn : mn - s;
			vr = (64'(W_VAR_OLD) * vr + 64'(W_VAR_NEW) * d + 32768) >> 16;
			mn = (64'(W_MEAN_OLD) * mn + 64'(W_MEAN_NEW) * s + 32768) >> 16;
		end
		p_mean = mn[23:0]; p_var = vr[23:0]; p_mean_known = 1;
		return estimate_out(ST_MEASURED, raw);
	endfunction

	task automatic add_row(meas_t m, bit known, est_t r);
		row_t rw;
		rw.m = m; rw.known = known; rw.r = r;
		rows.insert(rows.size(), rw);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_FLOOR: p_floor = val;
			REG_CEIL:  p_ceil = val;
			REG_INIT:  p_init = val;
			default:   p_mult = val[3:0];
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// leaves in_valid high after the transfer so the next item can follow directly
	task automatic send_meas(meas_t m, bit known, est_t r);
		est_t p;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		{opcode, sent_count, elapsed_0, elapsed_1, elapsed_2, elapsed_3} <= m;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = estimate_step(m);
		if (known && p != r) begin
			errors++;
			$display("%0t: directed row disagrees, typed %p predicted %p", $time, r, p);
		end
		expected_q.insert(expected_q.size(), known ? r : p);
		n_items++;
	endtask

	function automatic logic [15:0] rnd_elapsed();
		case ($urandom_range(9))
			0: return 16'hFFFF;
			1: return 16'($urandom);
			2: return 0;
			default: return 16'($urandom_range(1500));
		endcase
	endfunction

	function automatic meas_t rnd_meas();
		meas_t m;
		logic [15:0] base;
		int k;
		m.op = ($urandom_range(39) == 0);
		k = $urandom_range(15);
		m.cnt = k < 6 ? 3'd1 : k < 13 ? 3'($urandom_range(2, 4)) : 3'($urandom);
		base = rnd_elapsed();
		// retried requests: older transmissions have longer elapsed times
		m.e3 = base;
		m.e2 = (m.e3 > 16'hFFFF - 400) ? 16'hFFFF : m.e3 + 16'($urandom_range(400));
		m.e1 = (m.e2 > 16'hFFFF - 400) ? 16'hFFFF : m.e2 + 16'($urandom_range(400));
		m.e0 = (m.e1 > 16'hFFFF - 400) ? 16'hFFFF : m.e1 + 16'($urandom_range(400));
		if ($urandom_range(7) == 0) begin
			m.e0 = rnd_elapsed(); m.e1 = rnd_elapsed();
			m.e2 = rnd_elapsed(); m.e3 = rnd_elapsed();
		end
		if (m.cnt == 1 && $urandom_range(1)) m.e0 = base;
		return m;
	endfunction

	// output side: stall and check
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		est_t got, want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("cycle limit reached");
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, raw_rtt, rto_ms, mean_rtt, var_rtt};
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, got);
			end else begin
				want = expected_q.pop_front();
				n_checked++;
				if (got.st != want.st) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, want.st, got.st);
				end
				if (got.raw != want.raw) begin
					errors++;
					$display("%0t: raw_rtt exp %0d got %0d", $time, want.raw, got.raw);
				end
				if (got.rto != want.rto) begin
					errors++;
					$display("%0t: rto_ms exp %0d got %0d", $time, want.rto, got.rto);
				end
				if (got.mean != want.mean) begin
					errors++;
					$display("%0t: mean_rtt exp %0h got %0h", $time, want.mean, got.mean);
				end
				if (got.var_q != want.var_q) begin
					errors++;
					$display("%0t: var_rtt exp %0h got %0h", $time, want.var_q, got.var_q);
				end
			end
		end
	end

	initial begin
		meas_t m;
		row_t rw;
		p_floor = 10; p_ceil = 1000; p_init = 250; p_mult = 2;
		clear_estimate();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed table: reset rto is ceil(2*250)=500
		add_row('{0, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1,
			'{ST_IGNORED, 16'd0, 20'd500, 24'd250 << 8, 24'd0});
		add_row('{1, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1,
			'{ST_CLEARED, 16'd0, 20'd500, 24'd250 << 8, 24'd0});
		// first unretried sample 0 becomes the minimum, so no floor: rto at its minimum
		add_row('{0, 3'd1, 16'd0, 16'd0, 16'd0, 16'd0}, 1,
			'{ST_MEASURED, 16'd0, 20'd5, 24'd0, 24'd0});
		add_row('{1, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1,
			'{ST_CLEARED, 16'd0, 20'd500, 24'd250 << 8, 24'd0});
		// ceiling clamp on first sample
		add_row('{0, 3'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0}, 1,
			'{ST_MEASURED, 16'hFFFF, 20'd6000, 24'd1000 << 8, 24'd500 << 8});
		add_row('{0, 3'd1, 16'd100, 0, 0, 0}, 0, '0);
		add_row('{0, 3'd2, 16'd400, 16'd150, 0, 0}, 0, '0);
		add_row('{0, 3'd4, 16'd900, 16'd50, 16'd40, 16'd30}, 0, '0);
		add_row('{0, 3'd7, 16'd900, 16'd600, 16'd300, 16'd120}, 0, '0);
		add_row('{0, 3'd3, 16'hFFFF, 16'hAAAA, 16'h5555, 0}, 0, '0);
		add_row('{0, 3'd1, 16'd20, 0, 0, 0}, 0, '0);
		add_row('{0, 3'd5, 16'd30, 16'd25, 16'd22, 16'd21}, 0, '0);
		add_row('{0, 3'd0, 16'd1, 16'd2, 16'd3, 16'd4}, 0, '0);
		add_row('{0, 3'd1, 16'd700, 0, 0, 0}, 0, '0);
		add_row('{0, 3'd6, 16'd5000, 16'd4000, 16'd3000, 16'd2000}, 0, '0);
		foreach (rows[i]) send_meas(rows[i].m, rows[i].known, rows[i].r);
		drain();

		// zero multiplier, ceiling below floor
		write_reg(REG_MULT, 16'd0);
		write_reg(REG_FLOOR, 16'd500);
		write_reg(REG_CEIL, 16'd300);
		rw.m = '{1, 3'd0, 0, 0, 0, 0};
		send_meas(rw.m, 1, '{ST_CLEARED, 16'd0, 20'd5, 24'd250 << 8, 24'd0});
		for (int i = 0; i < 4; i++) send_meas(rnd_meas(), 0, '0);
		drain();
		// extremes: largest multiplier and initial mean, rto 15*65535
		write_reg(REG_MULT, 16'hF);
		write_reg(REG_INIT, 16'hFFFF);
		write_reg(REG_CEIL, 16'hFFFF);
		write_reg(REG_FLOOR, 16'hFFFF);
		rw.m = '{1, 3'd0, 0, 0, 0, 0};
		send_meas(rw.m, 1, '{ST_CLEARED, 16'd0, 20'd983025, 24'hFFFF00, 24'd0});
		for (int i = 0; i < 8; i++) send_meas(rnd_meas(), 0, '0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 32 : ph == 1 ? 85 : 0;
			recv_idle = ph == 0 ? 85 : ph == 1 ? 32 : 0;
			for (int set = 0; set < 3; set++) begin
				write_reg(REG_FLOOR, set == 0 ? 16'd0 : 16'($urandom_range(200)));
				write_reg(REG_CEIL, set == 0 ? 16'd1 : 16'($urandom_range(100, 65535)));
				write_reg(REG_INIT, 16'($urandom));
				write_reg(REG_MULT, 16'($urandom_range(1, 15)));
				if (ph == 2 && set == 0) begin
					// long receiver hold-off while items keep coming
					fork
						begin
							hold_off = 1;
							repeat (300) @(posedge clk);
							hold_off = 0;
						end
					join_none
				end
				for (int i = 0; i < 150; i++) send_meas(rnd_meas(), 0, '0);
				drain();
			end
		end

		$display("checked %0d results from %0d items over nine register settings,",
			n_checked, n_items);
		$display("three idling mixes, clears, retries and a long output hold-off");
		if (errors == 0 && expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
